### design/hl2s_pkg.sv
// Package: threshold table and constants for the half-float to sRGB8 pixel unit
package hl2s_pkg;

    // Half code of 1.0; every non-negative code above it is clamped to this
    localparam logic [15:0] HALF_ONE = 16'h3C00;

    // Output alpha is always opaque
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // Exponent field of a binary16 code, all ones for NaN and infinity
    localparam logic [15:0] EXP_MASK = 16'h7C00;

    // Width of the exact comparison values used while building the table
    localparam int BigW = 320;

    // Last byte step handled by the linear segment of the curve
    localparam int LinearLastStep = 10;

    // Step k: smallest half code whose sRGB value reaches (k - 0.5)/255
    typedef logic [255:0][15:0] thr_table_t;

    // Build the 255 step thresholds by exact integer comparison.
    // Linear segment: 12.92*v >= (2k-1)/510  <=>  65892*m >= 10*(2k-1)*2^nq.
    // Power segment:  v^(5/12) >= (40k+541)/10761
    //                 <=>  m^5 * 10761^12 >= (40k+541)^12 * 2^(5*nq).
    function automatic thr_table_t build_thresholds();
        thr_table_t       tab;
        logic [BigW-1:0]  den12;
        logic [BigW-1:0]  kpow;
        logic [BigW-1:0]  lhs;
        logic [BigW-1:0]  rhs;
        logic [63:0]      m5;
        logic [63:0]      lin_lhs;
        logic [63:0]      lin_rhs;
        logic [10:0]      m;
        int               k;
        int               j;
        int               lo;
        int               hi;
        int               mid;
        int               e;
        int               nq;
        bit               hit;

        den12 = BigW'(1);
        for (j = 0; j < 12; j++)
        begin
            den12 = den12 * BigW'(10761);
        end

        tab[0] = 16'h0000;
        for (k = 1; k < 256; k++)
        begin
            kpow = BigW'(1);
            for (j = 0; j < 12; j++)
            begin
                kpow = kpow * BigW'(40 * k + 541);
            end
            lo = 0;
            hi = int'(HALF_ONE);
            while (lo < hi)
            begin
                mid = (lo + hi) >> 1;
                e   = (mid >> 10) & 31;
                m   = 11'(mid & 1023);
                if (e == 0)
                begin
                    nq = 24;
                end
                else
                begin
                    m  = m | 11'h400;
                    nq = 25 - e;
                end
                if (k <= LinearLastStep)
                begin
                    lin_lhs = 64'(m) * 64'd65892;
                    lin_rhs = 64'(10 * (2 * k - 1)) << nq;
                    hit     = (lin_lhs >= lin_rhs);
                end
                else
                begin
                    m5 = 64'(m);
                    m5 = m5 * 64'(m);
                    m5 = m5 * 64'(m);
                    m5 = m5 * 64'(m);
                    m5 = m5 * 64'(m);
                    lhs = den12 * BigW'(m5);
                    rhs = kpow << (5 * nq);
                    hit = (lhs >= rhs);
                end
                if (hit)
                begin
                    hi = mid;
                end
                else
                begin
                    lo = mid + 1;
                end
            end
            tab[k] = 16'(lo);
        end
        return tab;
    endfunction

    localparam thr_table_t THR_TABLE = build_thresholds();

endpackage

### design/half_linear_to_srgb8_pixel_unit.sv
// Top level: half-float linear RGB pixel to sRGB 8-bit BGRA pixel, one pixel per clock while out_ready holds
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  in      | in_valid / in_ready  | red_half, green_half, blue_half (binary16)
//  out     | out_valid / out_ready| blue_byte, green_byte, red_byte, alpha_byte,
//          |                      | not_finite
//
// An item passes an input register and then a result register, and can leave once
// it sits in the result register; one item per cycle sustained while out_ready
// holds. The threshold compares and step search sit between those two
// registers.
// Reset clears both valid flags only. A stall at the output holds the result
// register; the input register keeps taking items while it is free.
module half_linear_to_srgb8_pixel_unit
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] red_half,
    input  logic [15:0] green_half,
    input  logic [15:0] blue_half,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  blue_byte,
    output logic [7:0]  green_byte,
    output logic [7:0]  red_byte,
    output logic [7:0]  alpha_byte,
    output logic        not_finite
);

    logic        in_vld_reg;
    logic [15:0] red_reg;
    logic [15:0] green_reg;
    logic [15:0] blue_reg;

    logic        res_vld_reg;
    logic [7:0]  blue_byte_reg;
    logic [7:0]  green_byte_reg;
    logic [7:0]  red_byte_reg;
    logic        not_finite_reg;

    logic        res_free;
    logic        in_free;
    logic        nf_next;
    logic [7:0]  red_enc;
    logic [7:0]  green_enc;
    logic [7:0]  blue_enc;

    // Advance each stage when the stage after it is free
    assign res_free = !res_vld_reg || out_ready;
    assign in_free  = !in_vld_reg || res_free;
    assign in_ready = in_free;

    // Hold the accepted item in the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_free)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_free && in_valid)
        begin
            red_reg   <= red_half;
            green_reg <= green_half;
            blue_reg  <= blue_half;
        end
    end

    // Encode the three channels
    hl2s_channel_enc u_red_enc
    (
        .code     (red_reg),
        .byte_out (red_enc)
    );

    hl2s_channel_enc u_green_enc
    (
        .code     (green_reg),
        .byte_out (green_enc)
    );

    hl2s_channel_enc u_blue_enc
    (
        .code     (blue_reg),
        .byte_out (blue_enc)
    );

    // Flag NaN or infinity in any channel
    assign nf_next = ((red_reg   & hl2s_pkg::EXP_MASK) == hl2s_pkg::EXP_MASK) ||
                     ((green_reg & hl2s_pkg::EXP_MASK) == hl2s_pkg::EXP_MASK) ||
                     ((blue_reg  & hl2s_pkg::EXP_MASK) == hl2s_pkg::EXP_MASK);

    // Load the result register; drop the color bytes of a non-finite pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (res_free)
        begin
            res_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_free && in_vld_reg)
        begin
            blue_byte_reg  <= nf_next ? 8'h00 : blue_enc;
            green_byte_reg <= nf_next ? 8'h00 : green_enc;
            red_byte_reg   <= nf_next ? 8'h00 : red_enc;
            not_finite_reg <= nf_next;
        end
    end

    assign out_valid  = res_vld_reg;
    assign blue_byte  = blue_byte_reg;
    assign green_byte = green_byte_reg;
    assign red_byte   = red_byte_reg;
    assign alpha_byte = hl2s_pkg::ALPHA_OPAQUE;
    assign not_finite = not_finite_reg;

endmodule

### design/hl2s_channel_enc.sv
// One color channel: clamp a binary16 code to [0,1] and map it to an sRGB byte
module hl2s_channel_enc
(
    input  logic [15:0] code,
    output logic [7:0]  byte_out
);

    logic [15:0]  clamped;
    logic [255:0] therm;
    logic [7:0]   idx;

    // Clamp negatives (sign set, including -0) to zero and large values to one
    always_comb
    begin
        if (code[15])
        begin
            clamped = 16'h0000;
        end
        else if (code > hl2s_pkg::HALF_ONE)
        begin
            clamped = hl2s_pkg::HALF_ONE;
        end
        else
        begin
            clamped = code;
        end
    end

    // Compare against every step threshold; the result is a thermometer code
    always_comb
    begin
        therm[0] = 1'b1;
        for (int k = 1; k < 256; k++)
        begin
            therm[k] = (hl2s_pkg::THR_TABLE[k] <= clamped);
        end
    end

    // Find the highest step reached, one bit at a time from the top
    always_comb
    begin
        idx = 8'h00;
        for (int b = 7; b >= 0; b--)
        begin
            if (therm[idx | (8'h01 << b)])
            begin
                idx = idx | (8'h01 << b);
            end
        end
    end

    assign byte_out = idx;

endmodule
